### src/mcp_pkg.sv
// Shared types and constants for the Monte Carlo call payoff averaging core.
// No dependencies; every other file in src imports this package.
package mcp_pkg;

  // Datapath widths
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned EXP_W     = 44;
  localparam int unsigned RED_BITS  = 5;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPOT      = 3'd0,
    CFG_STRIKE    = 3'd1,
    CFG_DRIFT     = 3'd2,
    CFG_DIFFUSION = 3'd3,
    CFG_DISCOUNT  = 3'd4
  } cfg_idx_e;

  // Register reset values
  localparam logic        [15:0] SPOT_RST      = 16'd100;
  localparam logic        [15:0] STRIKE_RST    = 16'd110;
  localparam logic signed [31:0] DRIFT_RST     = 32'sd0;
  localparam logic        [30:0] DIFFUSION_RST = 31'd53687091;
  localparam logic        [31:0] DISCOUNT_RST  = 32'd2022380289;

  // Exponential constants: ln 2 in Q.32, bias that keeps the reduced argument
  // positive (12 * ln 2), clamp limit of x in Q.28, last Taylor order.
  localparam logic        [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic        [4:0]  K_BIAS      = 5'd12;
  localparam logic        [36:0] RED_OFFSET  = 37'd35724533664;
  localparam logic signed [36:0] X_LIMIT     = 37'sd2147483648;
  localparam logic        [32:0] ONE_Q32     = 33'h1_0000_0000;
  localparam logic        [3:0]  TAYLOR_LAST = 4'd14;

  typedef struct packed {
    logic signed [31:0] normal_sample;
    logic               last_sample;
  } mcp_in_t;

  typedef struct packed {
    logic [47:0] option_price;
    logic        sum_saturated;
  } mcp_out_t;

  // floor(2^32 / i) for the Taylor divisors 2..14
  function automatic logic [31:0] mcp_recip(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      4'd13:   r = 32'h13B1_3B13;
      4'd14:   r = 32'h1249_2492;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

### src/monte_carlo_call_payoff_average_core.sv
// Monte Carlo call payoff averaging core: exp by range reduction and Taylor series.
// A new item is accepted only in the idle state, after the last one is through; each
// of the 13 Taylor terms makes two passes through the shared multiplier, and a last
// item adds the mean divide and the discount multiply.
// Asynchronous active-low reset restores the register defaults and clears sum, count
// and overflow flag; depends on mcp_pkg, mcp_mul and mcp_div.
module monte_carlo_call_payoff_average_core #(
  parameter int unsigned COUNT_BITS = 21
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mcp_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [mcp_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  mcp_pkg::mcp_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output mcp_pkg::mcp_out_t               out_data_o
);
  import mcp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_XMUL, S_XADD, S_RED, S_T1, S_TMUL, S_TREC, S_TFIX, S_SHIFT,
    S_PLO, S_PHI, S_ACC, S_DSTART, S_DWAIT, S_DLO, S_DHI, S_DOUT, S_DSEND
  } state_e;

  localparam int unsigned BIT_W = $clog2(RED_BITS);

  state_e state_q, state_d;

  // Configuration
  logic        [15:0] spot_q, strike_q;
  logic signed [31:0] drift_q;
  logic        [30:0] diff_q;
  logic        [31:0] disc_q;

  // Run state
  logic [SUM_W-1:0]      acc_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  flag_q;
  logic                  out_valid_q;
  mcp_out_t              out_q;

  // Sequencer counters
  logic [BIT_W-1:0] bit_q;
  logic [3:0]       i_q;

  // Working registers
  logic signed [31:0] z_q;
  logic               last_q;
  logic [36:0]        v_q;
  logic [4:0]         kq_q;
  logic [31:0]        term_q, t_q;
  logic [32:0]        sum_exp_q;
  logic [EXP_W-1:0]   exp_q;
  logic [47:0]        plo_q, res_q;
  logic [63:0]        pl_q;

  // Shared units
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic               div_start, div_done;
  logic [SUM_W-1:0]   div_quo;

  mcp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mcp_div #(.DIVISOR_W(COUNT_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Scaled draw: x = floor(z * diffusion / 2^28) + drift, clamped
  logic [31:0]        zmag;
  logic [34:0]        xq;
  logic signed [36:0] xs, xsum, xcl;
  logic [36:0]        v_init;

  assign zmag   = z_q[31] ? 32'(-z_q) : 32'(z_q);
  assign xq     = {1'b0, mul_p[61:28]} + 35'(z_q[31] && (|mul_p[27:0]));
  assign xs     = z_q[31] ? -$signed({2'b00, xq}) : $signed({2'b00, xq});
  assign xsum   = xs + 37'(drift_q);
  assign xcl    = (xsum > X_LIMIT) ? X_LIMIT : ((xsum < -X_LIMIT) ? -X_LIMIT : xsum);
  assign v_init = {xcl[32:0], 4'b0000} + RED_OFFSET;

  // Range reduction step
  logic [36:0] red_div;
  logic        red_ge;

  assign red_div = 37'(LN2_Q32) << bit_q;
  assign red_ge  = v_q >= red_div;

  // Taylor term correction: quotient estimate is low by at most one
  logic [31:0] q0, qf;
  logic [35:0] qi, rem;
  logic        fix;

  assign q0  = mul_p[63:32];
  assign qi  = 36'(q0) * 36'(i_q);
  assign rem = {4'b0000, t_q} - qi;
  assign fix = rem >= 36'(i_q);
  assign qf  = q0 + 32'(fix);

  // Payoff and saturating sum
  logic [59:0]        price, kq60, pdiff;
  logic [43:0]        payoff;
  logic [SUM_W:0]     acc_sum;

  assign price   = {mul_p[27:0], 32'h0000_0000} + {12'h000, plo_q};
  assign kq60    = {12'h000, strike_q, 32'h0000_0000};
  assign pdiff   = price - kq60;
  assign payoff  = (price > kq60) ? pdiff[59:16] : 44'd0;
  assign acc_sum = {1'b0, acc_q} + (SUM_W+1)'(payoff);

  // Discounted mean
  logic [95:0] prod96;

  assign prod96 = {32'h0000_0000, pl_q} + {mul_p, 32'h0000_0000};

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_q)
      S_XMUL: begin
        mul_a = zmag;
        mul_b = {1'b0, diff_q};
      end
      S_TMUL: begin
        mul_a = term_q;
        mul_b = v_q[31:0];
      end
      S_TREC: begin
        mul_a = mul_p[63:32];
        mul_b = mcp_recip(i_q);
      end
      S_PLO: begin
        mul_a = exp_q[31:0];
        mul_b = {16'h0000, spot_q};
      end
      S_PHI: begin
        mul_a = {20'h00000, exp_q[43:32]};
        mul_b = {16'h0000, spot_q};
      end
      S_DSTART: div_start = 1'b1;
      S_DLO: begin
        mul_a = div_quo[31:0];
        mul_b = disc_q;
      end
      S_DHI: begin
        mul_a = div_quo[63:32];
        mul_b = disc_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_XMUL;
      S_XMUL:   state_d = S_XADD;
      S_XADD:   state_d = S_RED;
      S_RED:    if (bit_q == '0) state_d = S_T1;
      S_T1:     state_d = S_TMUL;
      S_TMUL:   state_d = S_TREC;
      S_TREC:   state_d = S_TFIX;
      S_TFIX:   state_d = (i_q == TAYLOR_LAST) ? S_SHIFT : S_TMUL;
      S_SHIFT:  state_d = S_PLO;
      S_PLO:    state_d = S_PHI;
      S_PHI:    state_d = S_ACC;
      S_ACC:    state_d = last_q ? S_DSTART : S_IDLE;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT:  if (div_done) state_d = S_DLO;
      S_DLO:    state_d = S_DHI;
      S_DHI:    state_d = S_DOUT;
      S_DOUT:   state_d = S_DSEND;
      S_DSEND:  if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      spot_q      <= SPOT_RST;
      strike_q    <= STRIKE_RST;
      drift_q     <= DRIFT_RST;
      diff_q      <= DIFFUSION_RST;
      disc_q      <= DISCOUNT_RST;
      acc_q       <= '0;
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      bit_q       <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_SPOT:      spot_q   <= cfg_wdata_i[15:0];
          CFG_STRIKE:    strike_q <= cfg_wdata_i[15:0];
          CFG_DRIFT:     drift_q  <= $signed(cfg_wdata_i);
          CFG_DIFFUSION: diff_q   <= cfg_wdata_i[30:0];
          CFG_DISCOUNT:  disc_q   <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (state_q == S_DSEND && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_XADD: bit_q <= BIT_W'(RED_BITS - 1);
        S_RED:  bit_q <= bit_q - BIT_W'(1);
        S_T1:   i_q   <= 4'd2;
        S_TFIX: i_q   <= i_q + 4'd1;
        S_ACC: begin
          // stick at full scale on overflow
          if (acc_sum[SUM_W]) begin
            acc_q  <= '1;
            flag_q <= 1'b1;
          end else begin
            acc_q <= acc_sum[SUM_W-1:0];
          end
          if (!(&cnt_q)) cnt_q <= cnt_q + COUNT_BITS'(1);
        end
        S_DSEND: begin
          if (out_free) begin
            out_q.option_price  <= res_q;
            out_q.sum_saturated <= flag_q;
            acc_q               <= '0;
            cnt_q               <= '0;
            flag_q              <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          z_q    <= in_data_i.normal_sample;
          last_q <= in_data_i.last_sample;
        end
      end
      S_XADD: begin
        v_q  <= v_init;
        kq_q <= '0;
      end
      S_RED: begin
        if (red_ge) v_q <= v_q - red_div;
        kq_q <= {kq_q[3:0], red_ge};
      end
      S_T1: begin
        term_q    <= v_q[31:0];
        sum_exp_q <= ONE_Q32 + 33'(v_q[31:0]);
      end
      S_TREC: t_q <= mul_p[63:32];
      S_TFIX: begin
        term_q    <= qf;
        sum_exp_q <= sum_exp_q + 33'(qf);
      end
      S_SHIFT: begin
        // scale by 2^k, k = kq - bias
        if (kq_q >= K_BIAS) exp_q <= EXP_W'(sum_exp_q) << (kq_q - K_BIAS);
        else                exp_q <= EXP_W'(sum_exp_q) >> (K_BIAS - kq_q);
      end
      S_PHI:  plo_q <= mul_p[47:0];
      S_DHI:  pl_q  <= mul_p;
      S_DOUT: res_q <= (|prod96[95:79]) ? 48'hFFFF_FFFF_FFFF : prod96[78:31];
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again while an item is in progress");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DWAIT))
    else $error("divider finished outside the wait state");

  a_reduced_below_ln2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_T1) |-> (v_q < 37'(LN2_Q32)))
    else $error("range reduction left remainder at or above ln 2");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DSTART) |-> (cnt_q != '0))
    else $error("mean divide started with an empty count");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DSEND && out_free) |=> out_valid_o)
    else $error("result transfer lost");

endmodule

### src/mcp_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on mcp_pkg for the operand width.
module mcp_mul (
  input  logic                             clk_i,
  input  logic [mcp_pkg::MUL_W-1:0]        a_i,
  input  logic [mcp_pkg::MUL_W-1:0]        b_i,
  output logic [2*mcp_pkg::MUL_W-1:0]      p_o
);
  import mcp_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*MUL_W)'(a_i) * (2*MUL_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

### src/mcp_div.sv
// Restoring divider, one quotient bit per cycle while busy, for the end-of-run mean.
// Depends on mcp_pkg for the dividend width.
module mcp_div #(
  parameter int unsigned DIVISOR_W = 21
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mcp_pkg::SUM_W-1:0]  dividend_i,
  input  logic [DIVISOR_W-1:0]       divisor_i,
  output logic                       done_o,
  output logic [mcp_pkg::SUM_W-1:0]  quotient_o
);
  import mcp_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [STEP_W-1:0]    step_q;
  logic [SUM_W-1:0]     quo_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] dvs_q;

  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
